[hw/rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL files.
// Both macros sample on the rising edge of clk_i and are off during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every sampled edge.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLY(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

`endif

[hw/rtl/hsv2rgb_pkg.sv]
// ---------------------------------------------------------------------------
// hsv2rgb_pkg
// Constants, types and helper functions of the HSV to RGB converter.
// ---------------------------------------------------------------------------
package hsv2rgb_pkg;

  // Arithmetic constants of the conversion.
  localparam int unsigned SectorSteps = 10923;
  localparam int unsigned RgCap       = 341;
  localparam int unsigned Full16      = 65535;
  localparam int unsigned Full8       = 255;

  // Quotient bits produced by the divider, one per stage.
  localparam int unsigned QuotBits    = 8;

  // Hue sectors of the colour circle.
  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } sector_e;

  // One input pixel as it leaves the stream port.
  typedef struct packed {
    logic        yellow_fix;
    logic [7:0]  brightness;
    logic [7:0]  saturation;
    logic [15:0] hue;
  } pix_in_t;

  // Beat carried through the divider stages. The accumulators start as the
  // scaled numerators and end with the quotient in their low byte.
  typedef struct packed {
    logic [16:0] acc_r;
    logic [16:0] acc_g;
    logic [8:0]  divisor;
    logic [7:0]  blue;
  } div_beat_t;

  // Sector of a hue: the number of sector boundaries at or below it.
  function automatic sector_e sector_of(logic [15:0] hue);
    sector_e sec;
    if (hue >= 16'(5 * SectorSteps)) begin
      sec = SEC_MR;
    end else if (hue >= 16'(4 * SectorSteps)) begin
      sec = SEC_BM;
    end else if (hue >= 16'(3 * SectorSteps)) begin
      sec = SEC_CB;
    end else if (hue >= 16'(2 * SectorSteps)) begin
      sec = SEC_GC;
    end else if (hue >= 16'(SectorSteps)) begin
      sec = SEC_YG;
    end else begin
      sec = SEC_RY;
    end
    return sec;
  endfunction

  // First hue of a sector.
  function automatic logic [15:0] sector_base(sector_e sec);
    logic [15:0] base;
    case (sec)
      SEC_YG:  base = 16'(SectorSteps);
      SEC_GC:  base = 16'(2 * SectorSteps);
      SEC_CB:  base = 16'(3 * SectorSteps);
      SEC_BM:  base = 16'(4 * SectorSteps);
      SEC_MR:  base = 16'(5 * SectorSteps);
      default: base = 16'd0;
    endcase
    return base;
  endfunction

  // One restoring division step: shift in the next numerator bit, subtract
  // the divisor if it fits and shift the quotient bit in at the bottom.
  function automatic logic [16:0] div_step(logic [16:0] acc, logic [8:0] divisor);
    logic [9:0]  trial;
    logic [9:0]  diff;
    logic [16:0] res;
    trial = {acc[16:8], acc[7]};
    diff  = trial - {1'b0, divisor};
    if (trial >= {1'b0, divisor}) begin
      res = {diff[8:0], acc[6:0], 1'b1};
    end else begin
      res = {trial[8:0], acc[6:0], 1'b0};
    end
    return res;
  endfunction

endpackage

[hw/rtl/hsv2rgb_front.sv]
// ---------------------------------------------------------------------------
// hsv2rgb_front
// Five-stage front end: sector split, level products, channel selection and
// scaling of red and green for the yellow correction divider.
// ---------------------------------------------------------------------------
module hsv2rgb_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  hsv2rgb_pkg::pix_in_t   in_pix_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output hsv2rgb_pkg::div_beat_t out_beat_o
);

  // Stage valid bits and the ready chain between stages.
  logic vld1_q, vld2_q, vld3_q, vld4_q, vld5_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5 = !vld5_q || out_ready_i;
  assign rdy4 = !vld4_q || rdy5;
  assign rdy3 = !vld3_q || rdy4;
  assign rdy2 = !vld2_q || rdy3;
  assign rdy1 = !vld1_q || rdy2;
  assign in_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
      vld5_q <= 1'b0;
    end else begin
      if (rdy1) vld1_q <= in_valid_i;
      if (rdy2) vld2_q <= vld1_q;
      if (rdy3) vld3_q <= vld2_q;
      if (rdy4) vld4_q <= vld3_q;
      if (rdy5) vld5_q <= vld4_q;
    end
  end

  // Stage 1: sector and remainder within the sector, scaled by six.
  hsv2rgb_pkg::sector_e sec1_d, sec1_q;
  logic [13:0] rem_d;
  logic [16:0] rem6_w;
  logic [15:0] rem6_d, rem6_q;
  logic [7:0]  sat1_q, bri1_q;
  logic        fix1_q;

  always_comb begin
    sec1_d = hsv2rgb_pkg::sector_of(in_pix_i.hue);
    rem_d  = 14'(in_pix_i.hue - hsv2rgb_pkg::sector_base(sec1_d));
    rem6_w = {1'b0, rem_d, 2'b00} + {2'b00, rem_d, 1'b0};
    rem6_d = rem6_w[15:0];
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      sec1_q <= sec1_d;
      rem6_q <= rem6_d;
      sat1_q <= in_pix_i.saturation;
      bri1_q <= in_pix_i.brightness;
      fix1_q <= in_pix_i.yellow_fix;
    end
  end

  // Stage 2: saturation products for q and t, and the level p.
  logic [23:0] prod_q_w, prod_t_w;
  logic [15:0] prod_p_w;
  logic [7:0]  sq2_q, st2_q, p2_q, bri2_q;
  logic        grey2_q, fix2_q;
  hsv2rgb_pkg::sector_e sec2_q;

  always_comb begin
    prod_q_w = {16'd0, sat1_q} * {8'd0, rem6_q};
    prod_t_w = {16'd0, sat1_q} * {8'd0, 16'(hsv2rgb_pkg::Full16) - rem6_q};
    prod_p_w = {8'd0, bri1_q} * {8'd0, 8'(hsv2rgb_pkg::Full8) - sat1_q};
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      sq2_q   <= prod_q_w[23:16];
      st2_q   <= prod_t_w[23:16];
      p2_q    <= prod_p_w[15:8];
      bri2_q  <= bri1_q;
      grey2_q <= (sat1_q == 8'd0);
      fix2_q  <= fix1_q;
      sec2_q  <= sec1_q;
    end
  end

  // Stage 3: the levels q and t.
  logic [15:0] prod_qv_w, prod_tv_w;
  logic [7:0]  q3_q, t3_q, p3_q, bri3_q;
  logic        grey3_q, fix3_q;
  hsv2rgb_pkg::sector_e sec3_q;

  always_comb begin
    prod_qv_w = {8'd0, bri2_q} * {8'd0, 8'(hsv2rgb_pkg::Full8) - sq2_q};
    prod_tv_w = {8'd0, bri2_q} * {8'd0, 8'(hsv2rgb_pkg::Full8) - st2_q};
  end

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      q3_q    <= prod_qv_w[15:8];
      t3_q    <= prod_tv_w[15:8];
      p3_q    <= p2_q;
      bri3_q  <= bri2_q;
      grey3_q <= grey2_q;
      fix3_q  <= fix2_q;
      sec3_q  <= sec2_q;
    end
  end

  // Stage 4: channel selection by sector, grey override and the decision
  // whether red plus green must be capped.
  logic [7:0] r4_d, g4_d, b4_d, r4_q, g4_q, b4_q;
  logic [8:0] sum4_d, div4_d, div4_q;
  logic       cap4_d;

  always_comb begin
    case (sec3_q)
      hsv2rgb_pkg::SEC_RY: begin r4_d = bri3_q; g4_d = t3_q;   b4_d = p3_q;   end
      hsv2rgb_pkg::SEC_YG: begin r4_d = q3_q;   g4_d = bri3_q; b4_d = p3_q;   end
      hsv2rgb_pkg::SEC_GC: begin r4_d = p3_q;   g4_d = bri3_q; b4_d = t3_q;   end
      hsv2rgb_pkg::SEC_CB: begin r4_d = p3_q;   g4_d = q3_q;   b4_d = bri3_q; end
      hsv2rgb_pkg::SEC_BM: begin r4_d = t3_q;   g4_d = p3_q;   b4_d = bri3_q; end
      default:             begin r4_d = bri3_q; g4_d = p3_q;   b4_d = q3_q;   end
    endcase
    if (grey3_q) begin
      r4_d = bri3_q;
      g4_d = bri3_q;
      b4_d = bri3_q;
    end
    sum4_d = {1'b0, r4_d} + {1'b0, g4_d};
    cap4_d = fix3_q && !grey3_q && sum4_d > 9'(hsv2rgb_pkg::RgCap)
             && (sec3_q == hsv2rgb_pkg::SEC_RY || sec3_q == hsv2rgb_pkg::SEC_YG);
    // Without capping, dividing x*341 by 341 returns x unchanged.
    div4_d = cap4_d ? sum4_d : 9'(hsv2rgb_pkg::RgCap);
  end

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      r4_q   <= r4_d;
      g4_q   <= g4_d;
      b4_q   <= b4_d;
      div4_q <= div4_d;
    end
  end

  // Stage 5: numerators of the proportional cap.
  hsv2rgb_pkg::div_beat_t beat5_d, beat5_q;

  always_comb begin
    beat5_d.acc_r   = {9'd0, r4_q} * 17'(hsv2rgb_pkg::RgCap);
    beat5_d.acc_g   = {9'd0, g4_q} * 17'(hsv2rgb_pkg::RgCap);
    beat5_d.divisor = div4_q;
    beat5_d.blue    = b4_q;
  end

  always_ff @(posedge clk_i) begin
    if (rdy5) begin
      beat5_q <= beat5_d;
    end
  end

  assign out_valid_o = vld5_q;
  assign out_beat_o  = beat5_q;

endmodule

[hw/rtl/hsv2rgb_div.sv]
// ---------------------------------------------------------------------------
// hsv2rgb_div
// Pipelined restoring divider, one quotient bit per stage, for the red and
// green lanes side by side. Blue travels alongside unchanged.
// ---------------------------------------------------------------------------
module hsv2rgb_div (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  hsv2rgb_pkg::div_beat_t in_beat_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output hsv2rgb_pkg::div_beat_t out_beat_o
);

  // Per-stage valid bits, payload and ready chain.
  logic [hsv2rgb_pkg::QuotBits-1:0] vld_q;
  logic [hsv2rgb_pkg::QuotBits:0]   rdy;
  hsv2rgb_pkg::div_beat_t           stage_q   [hsv2rgb_pkg::QuotBits];
  hsv2rgb_pkg::div_beat_t           next_beat [hsv2rgb_pkg::QuotBits];

  // One division step on both lanes; divisor and blue pass through.
  function automatic hsv2rgb_pkg::div_beat_t div_stage(hsv2rgb_pkg::div_beat_t beat);
    hsv2rgb_pkg::div_beat_t res;
    res       = beat;
    res.acc_r = hsv2rgb_pkg::div_step(beat.acc_r, beat.divisor);
    res.acc_g = hsv2rgb_pkg::div_step(beat.acc_g, beat.divisor);
    return res;
  endfunction

  // A stage takes a beat when it is empty or its own beat moves on.
  always_comb begin
    rdy[hsv2rgb_pkg::QuotBits] = out_ready_i;
    for (int k = int'(hsv2rgb_pkg::QuotBits) - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign in_ready_o = rdy[0];

  // The first stage works on the incoming beat, the others on their
  // predecessor.
  always_comb begin
    next_beat[0] = div_stage(in_beat_i);
    for (int k = 1; k < int'(hsv2rgb_pkg::QuotBits); k++) begin
      next_beat[k] = div_stage(stage_q[k-1]);
    end
  end

  // Valid bits advance with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < int'(hsv2rgb_pkg::QuotBits); k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // Stage payload registers.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < int'(hsv2rgb_pkg::QuotBits); k++) begin
      if (rdy[k]) begin
        stage_q[k] <= next_beat[k];
      end
    end
  end

  assign out_valid_o = vld_q[hsv2rgb_pkg::QuotBits-1];
  assign out_beat_o  = stage_q[hsv2rgb_pkg::QuotBits-1];

endmodule

[hw/rtl/hsv_to_rgb_yellow_correct.sv]
// ---------------------------------------------------------------------------
// hsv_to_rgb_yellow_correct
// HSV to RGB pixel converter with optional yellow correction.
// ---------------------------------------------------------------------------
// Usage:
//   Pixels enter on the slave stream: one beat is one HSV pixel with its
//   yellow correction flag. Each beat yields exactly one RGB beat on the
//   master stream, in the same order.
//   Five front-end stages (sector split, two product stages, channel
//   selection, numerator scaling) and eight divider stages, one quotient
//   bit each, set the depth. The last divider stage is the output register.
//   Throughput is one pixel per clock while the receiver takes every beat.
//   When the receiver stalls, every stage that holds a beat keeps it and
//   empty stages still fill, so up to 13 beats are taken before s_axis_tready
//   falls; nothing is dropped or repeated.
//   Reset clears all stage valid bits; the block is ready in the first cycle
//   after rst_ni rises.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hsv_to_rgb_yellow_correct (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] hue, [23:16] saturation, [31:24] brightness, [32] yellow_fix,
  // [39:33] zero
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] red, [15:8] green, [23:16] blue
  output logic [23:0] m_axis_tdata
);

  // Unpack the input beat.
  hsv2rgb_pkg::pix_in_t in_pix;

  assign in_pix.hue        = s_axis_tdata[15:0];
  assign in_pix.saturation = s_axis_tdata[23:16];
  assign in_pix.brightness = s_axis_tdata[31:24];
  assign in_pix.yellow_fix = s_axis_tdata[32];

  // Front end to divider.
  logic                   front_vld, div_rdy;
  hsv2rgb_pkg::div_beat_t front_beat, out_beat;

  hsv2rgb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_pix_i    (in_pix),
    .out_valid_o (front_vld),
    .out_ready_i (div_rdy),
    .out_beat_o  (front_beat)
  );

  hsv2rgb_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (front_vld),
    .in_ready_o  (div_rdy),
    .in_beat_i   (front_beat),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_beat_o  (out_beat)
  );

  // Quotients sit in the low byte of each accumulator.
  assign m_axis_tdata = {out_beat.blue, out_beat.acc_g[7:0], out_beat.acc_r[7:0]};

  // Conditions watched by the assertions below.
  logic out_stall, quot_ok;

  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign quot_ok   = front_beat.divisor >= 9'(hsv2rgb_pkg::RgCap)
                     && front_beat.acc_r[16:8] < front_beat.divisor
                     && front_beat.acc_g[16:8] < front_beat.divisor;

  // The input can only be held off by a full pipeline behind a stalled output.
  `ASSERT_ALWAYS(a_stall_from_output, s_axis_tready || out_stall, "input stalled without an output stall")

  // Every divider beat has a divisor of at least the cap and numerators whose
  // upper bits lie below it, so each quotient fits in eight bits.
  `ASSERT_IMPLY(a_quot_fits, front_vld, quot_ok, "divider quotient would overflow")

endmodule
